// File: rtl/rsrt_pkg.sv
// ----------------------------------------------------------------------------
// Register status rename table package
// Shared sizes, id type, update command and range check for the table.
// ----------------------------------------------------------------------------
package rsrt_pkg;

  localparam int RSRT_NUM_REGS   = 32;
  localparam int RSRT_TAG_BITS   = 5;
  localparam int RSRT_DATA_WIDTH = 32;
  localparam int ID_W            = 5;

  typedef logic [ID_W-1:0] reg_id_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic wr_clr_busy;
    logic ap_en;
  } rsrt_upd_t;

  function automatic logic id_in_range(reg_id_t id, int num_regs);
    return int'(id) < num_regs;
  endfunction

endpackage

// File: rtl/rsrt_if.sv
// ----------------------------------------------------------------------------
// Register status rename table channels
// Valid/ready channels for access items and query results.
// ----------------------------------------------------------------------------
interface rsrt_in_if import rsrt_pkg::*; #(
  parameter int TAG_BITS   = RSRT_TAG_BITS,
  parameter int DATA_WIDTH = RSRT_DATA_WIDTH
) ();
  logic                  valid;
  logic                  ready;
  logic                  clear;
  logic                  write_en;
  reg_id_t               write_reg;
  logic [DATA_WIDTH-1:0] write_value;
  logic [TAG_BITS-1:0]   write_tag;
  logic                  append_en;
  reg_id_t               append_reg;
  logic [TAG_BITS-1:0]   append_tag;
  reg_id_t               src_a;
  reg_id_t               src_b;

  modport source (
    output valid, clear, write_en, write_reg, write_value, write_tag,
           append_en, append_reg, append_tag, src_a, src_b,
    input  ready
  );
  modport sink (
    input  valid, clear, write_en, write_reg, write_value, write_tag,
           append_en, append_reg, append_tag, src_a, src_b,
    output ready
  );
endinterface

interface rsrt_out_if import rsrt_pkg::*; #(
  parameter int TAG_BITS   = RSRT_TAG_BITS,
  parameter int DATA_WIDTH = RSRT_DATA_WIDTH
) ();
  logic                  valid;
  logic                  ready;
  logic                  a_busy;
  logic [DATA_WIDTH-1:0] a_value;
  logic [TAG_BITS-1:0]   a_tag;
  logic                  b_busy;
  logic [DATA_WIDTH-1:0] b_value;
  logic [TAG_BITS-1:0]   b_tag;

  modport source (
    output valid, a_busy, a_value, a_tag, b_busy, b_value, b_tag,
    input  ready
  );
  modport sink (
    input  valid, a_busy, a_value, a_tag, b_busy, b_value, b_tag,
    output ready
  );
endinterface

// File: rtl/rsrt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data (read-first).
// ----------------------------------------------------------------------------
module rsrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_0,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_1,
  output logic [WIDTH-1:0]                      rdata_0,
  output logic [WIDTH-1:0]                      rdata_1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_0 <= mem_r[raddr_0];
      rdata_1 <= mem_r[raddr_1];
    end
  end

endmodule

// File: rtl/rsrt_table.sv
// ----------------------------------------------------------------------------
// Register status table storage
// Busy marks and valid bits in flops, values and tags in RAMs, with
// forwarding of the update that lands on the same edge as the read.
// ----------------------------------------------------------------------------
module rsrt_table import rsrt_pkg::*; #(
  parameter int NUM_REGS   = RSRT_NUM_REGS,
  parameter int TAG_BITS   = RSRT_TAG_BITS,
  parameter int DATA_WIDTH = RSRT_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  reg_id_t               rd_a,
  input  reg_id_t               rd_b,
  input  reg_id_t               rd_w,
  input  reg_id_t               q_a,
  input  reg_id_t               q_b,
  input  reg_id_t               q_w,
  input  rsrt_upd_t             upd,
  input  reg_id_t               upd_wreg,
  input  logic [DATA_WIDTH-1:0] upd_wval,
  input  reg_id_t               upd_areg,
  input  logic [TAG_BITS-1:0]   upd_atag,
  output logic                  a_busy,
  output logic [TAG_BITS-1:0]   a_tag,
  output logic [DATA_WIDTH-1:0] a_val,
  output logic                  b_busy,
  output logic [TAG_BITS-1:0]   b_tag,
  output logic [DATA_WIDTH-1:0] b_val,
  output logic [TAG_BITS-1:0]   w_tag
);

  localparam int IDX_W = NUM_REGS > 1 ? $clog2(NUM_REGS) : 1;

  logic [NUM_REGS-1:0]   busy_r, busy_nxt;
  logic [NUM_REGS-1:0]   tvld_r, vvld_r;
  logic                  fw_en_r, fa_en_r;
  reg_id_t               fw_id_r, fa_id_r;
  logic [DATA_WIDTH-1:0] fw_val_r;
  logic [TAG_BITS-1:0]   fa_tag_r;
  logic [DATA_WIDTH-1:0] ram_va, ram_vb;
  logic [TAG_BITS-1:0]   ram_ta, ram_tb, ram_tw;
  logic [IDX_W-1:0]      widx, aidx, ia, ib, iw;
  logic                  ra, rb, rw;

  assign widx = IDX_W'(upd_wreg);
  assign aidx = IDX_W'(upd_areg);
  assign ia   = IDX_W'(q_a);
  assign ib   = IDX_W'(q_b);
  assign iw   = IDX_W'(q_w);
  assign ra   = id_in_range(q_a, NUM_REGS);
  assign rb   = id_in_range(q_b, NUM_REGS);
  assign rw   = id_in_range(q_w, NUM_REGS);

  rsrt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_val_ram (
    .clk     (clk),
    .we      (upd.wr_en),
    .waddr   (widx),
    .wdata   (upd_wval),
    .re      (rd_en),
    .raddr_0 (IDX_W'(rd_a)),
    .raddr_1 (IDX_W'(rd_b)),
    .rdata_0 (ram_va),
    .rdata_1 (ram_vb)
  );

  rsrt_ram #(.WIDTH(TAG_BITS), .DEPTH(NUM_REGS)) u_tag_src_ram (
    .clk     (clk),
    .we      (upd.ap_en),
    .waddr   (aidx),
    .wdata   (upd_atag),
    .re      (rd_en),
    .raddr_0 (IDX_W'(rd_a)),
    .raddr_1 (IDX_W'(rd_b)),
    .rdata_0 (ram_ta),
    .rdata_1 (ram_tb)
  );

  rsrt_ram #(.WIDTH(TAG_BITS), .DEPTH(NUM_REGS)) u_tag_wr_ram (
    .clk     (clk),
    .we      (upd.ap_en),
    .waddr   (aidx),
    .wdata   (upd_atag),
    .re      (rd_en),
    .raddr_0 (IDX_W'(rd_w)),
    .raddr_1 (IDX_W'(rd_w)),
    .rdata_0 (ram_tw),
    .rdata_1 ()
  );

  always_comb begin
    busy_nxt = busy_r;
    if (upd.clear) begin
      busy_nxt = '0;
    end else begin
      if (upd.wr_en && upd.wr_clr_busy) begin
        busy_nxt[widx] = 1'b0;
      end
      if (upd.ap_en) begin
        busy_nxt[aidx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      tvld_r  <= '0;
      vvld_r  <= '0;
      fw_en_r <= 1'b0;
      fa_en_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (upd.wr_en) begin
        vvld_r[widx] <= 1'b1;
      end
      if (upd.ap_en) begin
        tvld_r[aidx] <= 1'b1;
      end
      if (rd_en) begin
        fw_en_r <= upd.wr_en;
        fa_en_r <= upd.ap_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fw_id_r  <= upd_wreg;
      fw_val_r <= upd_wval;
      fa_id_r  <= upd_areg;
      fa_tag_r <= upd_atag;
    end
  end

  always_comb begin
    a_busy = ra && busy_r[ia];
    b_busy = rb && busy_r[ib];

    if (fw_en_r && fw_id_r == q_a) begin
      a_val = fw_val_r;
    end else if (ra && vvld_r[ia]) begin
      a_val = ram_va;
    end else begin
      a_val = '0;
    end

    if (fw_en_r && fw_id_r == q_b) begin
      b_val = fw_val_r;
    end else if (rb && vvld_r[ib]) begin
      b_val = ram_vb;
    end else begin
      b_val = '0;
    end

    if (fa_en_r && fa_id_r == q_a) begin
      a_tag = fa_tag_r;
    end else if (ra && tvld_r[ia]) begin
      a_tag = ram_ta;
    end else begin
      a_tag = '0;
    end

    if (fa_en_r && fa_id_r == q_b) begin
      b_tag = fa_tag_r;
    end else if (rb && tvld_r[ib]) begin
      b_tag = ram_tb;
    end else begin
      b_tag = '0;
    end

    if (fa_en_r && fa_id_r == q_w) begin
      w_tag = fa_tag_r;
    end else if (rw && tvld_r[iw]) begin
      w_tag = ram_tw;
    end else begin
      w_tag = '0;
    end
  end

endmodule

// File: rtl/rsrt_resolve.sv
// ----------------------------------------------------------------------------
// Source operand resolve
// Apply same-item append and commit bypass, then the register-zero and clear rules, to one stored entry.
// ----------------------------------------------------------------------------
module rsrt_resolve import rsrt_pkg::*; #(
  parameter int TAG_BITS   = RSRT_TAG_BITS,
  parameter int DATA_WIDTH = RSRT_DATA_WIDTH
) (
  input  reg_id_t               id,
  input  logic                  clear,
  input  logic                  write_en,
  input  reg_id_t               write_reg,
  input  logic [DATA_WIDTH-1:0] write_value,
  input  logic [TAG_BITS-1:0]   write_tag,
  input  logic                  append_en,
  input  reg_id_t               append_reg,
  input  logic [TAG_BITS-1:0]   append_tag,
  input  logic                  e_busy,
  input  logic [TAG_BITS-1:0]   e_tag,
  input  logic [DATA_WIDTH-1:0] e_val,
  output logic                  busy,
  output logic [TAG_BITS-1:0]   tag,
  output logic [DATA_WIDTH-1:0] val
);

  always_comb begin
    busy = e_busy;
    tag  = e_tag;
    val  = e_val;
    if (append_en && append_reg == id) begin
      busy = 1'b1;
      tag  = append_tag;
    end else if (write_en && write_reg == id && write_tag == e_tag) begin
      busy = 1'b0;
      val  = write_value;
    end
    if (id == '0) begin
      busy = 1'b0;
      val  = '0;
    end
    if (clear) begin
      busy = 1'b0;
    end
  end

endmodule

// File: rtl/register_status_rename_table_top.sv
// ----------------------------------------------------------------------------
// Register status rename table
// Busy/tag/value table for an out-of-order core with commit and rename.
// ----------------------------------------------------------------------------
// Takes one access item per clock: a commit write, a rename append, a clear
// and two source lookups. Each accepted item passes through the input/RAM
// read stage and then the result register, and a new item is accepted every
// cycle while results are taken. That rate is set by the table write-back:
// each item applies its write, append or clear to the value and tag RAMs and
// busy flops on the edge it leaves the input stage, and the update of that
// same edge is forwarded to the item read on it. Values and tags reset to
// zero through per-entry valid bits, so no clearing pass follows reset.
module register_status_rename_table_top import rsrt_pkg::*; #(
  parameter int NUM_REGS   = RSRT_NUM_REGS,
  parameter int TAG_BITS   = RSRT_TAG_BITS,
  parameter int DATA_WIDTH = RSRT_DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  rsrt_in_if.sink  in_if,
  rsrt_out_if.source out_if
);

  logic                  s1_valid_r;
  logic                  s1_clear_r, s1_we_r, s1_ae_r;
  reg_id_t               s1_wreg_r, s1_areg_r, s1_sa_r, s1_sb_r;
  logic [DATA_WIDTH-1:0] s1_wval_r;
  logic [TAG_BITS-1:0]   s1_wtag_r, s1_atag_r;
  logic                  out_valid_r;
  logic                  oa_busy_r, ob_busy_r;
  logic [DATA_WIDTH-1:0] oa_val_r, ob_val_r;
  logic [TAG_BITS-1:0]   oa_tag_r, ob_tag_r;

  logic                  accept, s1_adv;
  rsrt_upd_t             upd;
  logic                  ea_busy, eb_busy, ra_busy, rb_busy;
  logic [TAG_BITS-1:0]   ea_tag, eb_tag, ew_tag, ra_tag, rb_tag;
  logic [DATA_WIDTH-1:0] ea_val, eb_val, ra_val, rb_val;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    upd.clear       = s1_adv && s1_clear_r;
    upd.wr_en       = s1_adv && !s1_clear_r && s1_we_r
                      && id_in_range(s1_wreg_r, NUM_REGS);
    upd.wr_clr_busy = (ew_tag == s1_wtag_r);
    upd.ap_en       = s1_adv && !s1_clear_r && s1_ae_r
                      && id_in_range(s1_areg_r, NUM_REGS)
                      && !(s1_we_r && s1_wtag_r == s1_atag_r);
  end

  rsrt_table #(
    .NUM_REGS   (NUM_REGS),
    .TAG_BITS   (TAG_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_a     (in_if.src_a),
    .rd_b     (in_if.src_b),
    .rd_w     (in_if.write_reg),
    .q_a      (s1_sa_r),
    .q_b      (s1_sb_r),
    .q_w      (s1_wreg_r),
    .upd      (upd),
    .upd_wreg (s1_wreg_r),
    .upd_wval (s1_wval_r),
    .upd_areg (s1_areg_r),
    .upd_atag (s1_atag_r),
    .a_busy   (ea_busy),
    .a_tag    (ea_tag),
    .a_val    (ea_val),
    .b_busy   (eb_busy),
    .b_tag    (eb_tag),
    .b_val    (eb_val),
    .w_tag    (ew_tag)
  );

  rsrt_resolve #(.TAG_BITS(TAG_BITS), .DATA_WIDTH(DATA_WIDTH)) u_resolve_a (
    .id          (s1_sa_r),
    .clear       (s1_clear_r),
    .write_en    (s1_we_r),
    .write_reg   (s1_wreg_r),
    .write_value (s1_wval_r),
    .write_tag   (s1_wtag_r),
    .append_en   (s1_ae_r),
    .append_reg  (s1_areg_r),
    .append_tag  (s1_atag_r),
    .e_busy      (ea_busy),
    .e_tag       (ea_tag),
    .e_val       (ea_val),
    .busy        (ra_busy),
    .tag         (ra_tag),
    .val         (ra_val)
  );

  rsrt_resolve #(.TAG_BITS(TAG_BITS), .DATA_WIDTH(DATA_WIDTH)) u_resolve_b (
    .id          (s1_sb_r),
    .clear       (s1_clear_r),
    .write_en    (s1_we_r),
    .write_reg   (s1_wreg_r),
    .write_value (s1_wval_r),
    .write_tag   (s1_wtag_r),
    .append_en   (s1_ae_r),
    .append_reg  (s1_areg_r),
    .append_tag  (s1_atag_r),
    .e_busy      (eb_busy),
    .e_tag       (eb_tag),
    .e_val       (eb_val),
    .busy        (rb_busy),
    .tag         (rb_tag),
    .val         (rb_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_clear_r <= in_if.clear;
      s1_we_r    <= in_if.write_en;
      s1_wreg_r  <= in_if.write_reg;
      s1_wval_r  <= in_if.write_value;
      s1_wtag_r  <= in_if.write_tag;
      s1_ae_r    <= in_if.append_en;
      s1_areg_r  <= in_if.append_reg;
      s1_atag_r  <= in_if.append_tag;
      s1_sa_r    <= in_if.src_a;
      s1_sb_r    <= in_if.src_b;
    end
    if (s1_adv) begin
      oa_busy_r <= ra_busy;
      oa_tag_r  <= ra_tag;
      oa_val_r  <= ra_val;
      ob_busy_r <= rb_busy;
      ob_tag_r  <= rb_tag;
      ob_val_r  <= rb_val;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.a_busy  = oa_busy_r;
  assign out_if.a_value = oa_val_r;
  assign out_if.a_tag   = oa_tag_r;
  assign out_if.b_busy  = ob_busy_r;
  assign out_if.b_value = ob_val_r;
  assign out_if.b_tag   = ob_tag_r;

endmodule

// File: tb/register_status_rename_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Register status rename table lookup checker
// Watches the access and result channels, keeps its own busy/tag/value table,
// predicts both source lookups of every accepted access item from the table
// state before that item's update, and compares each accepted result field by
// field with the oldest pending lookup.
// ----------------------------------------------------------------------------
module register_status_rename_table_checker import rsrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rsrt_in_if         in_ch,
  rsrt_out_if        out_ch,
  output int         fail_count,
  output int         pending
);

  typedef logic [RSRT_TAG_BITS-1:0]   tag_t;
  typedef logic [RSRT_DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic  a_busy;
    data_t a_value;
    tag_t  a_tag;
    logic  b_busy;
    data_t b_value;
    tag_t  b_tag;
  } lookup_t;

  logic    busy_tbl  [RSRT_NUM_REGS];
  tag_t    tag_tbl   [RSRT_NUM_REGS];
  data_t   value_tbl [RSRT_NUM_REGS];
  lookup_t lookups_due[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic void lookup_src(input reg_id_t id, output logic busy,
                                     output data_t val, output tag_t tag);
    busy = busy_tbl[id];
    val  = value_tbl[id];
    tag  = tag_tbl[id];
    if (in_ch.append_en && in_ch.append_reg == id) begin
      busy = 1'b1;
      tag  = in_ch.append_tag;
    end else if (in_ch.write_en && in_ch.write_reg == id && in_ch.write_tag == tag) begin
      busy = 1'b0;
      val  = in_ch.write_value;
    end
    if (id == '0) begin
      busy = 1'b0;
      val  = '0;
    end
    if (in_ch.clear)
      busy = 1'b0;
  endfunction

  task automatic update_table();
    if (in_ch.clear) begin
      foreach (busy_tbl[i]) busy_tbl[i] = 1'b0;
    end else begin
      if (in_ch.write_en) begin
        value_tbl[in_ch.write_reg] = in_ch.write_value;
        if (tag_tbl[in_ch.write_reg] == in_ch.write_tag)
          busy_tbl[in_ch.write_reg] = 1'b0;
      end
      if (in_ch.append_en && !(in_ch.write_en && in_ch.write_tag == in_ch.append_tag)) begin
        busy_tbl[in_ch.append_reg] = 1'b1;
        tag_tbl[in_ch.append_reg]  = in_ch.append_tag;
      end
    end
  endtask

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      foreach (busy_tbl[i]) begin
        busy_tbl[i]  = 1'b0;
        tag_tbl[i]   = '0;
        value_tbl[i] = '0;
      end
      lookups_due.delete();
      fail_count = 0;
    end else begin
      // retire first: a result can never belong to an item accepted on the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (lookups_due.size() == 0) begin
          report_mismatch("result with no pending lookup");
        end else begin
          want = lookups_due.pop_front();
          compare_field("a_busy",  64'(out_ch.a_busy),  64'(want.a_busy));
          compare_field("a_value", 64'(out_ch.a_value), 64'(want.a_value));
          compare_field("a_tag",   64'(out_ch.a_tag),   64'(want.a_tag));
          compare_field("b_busy",  64'(out_ch.b_busy),  64'(want.b_busy));
          compare_field("b_value", 64'(out_ch.b_value), 64'(want.b_value));
          compare_field("b_tag",   64'(out_ch.b_tag),   64'(want.b_tag));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        lookup_src(in_ch.src_a, want.a_busy, want.a_value, want.a_tag);
        lookup_src(in_ch.src_b, want.b_busy, want.b_value, want.b_tag);
        lookups_due.push_back(want);
        update_table();
      end
    end
    pending = lookups_due.size();
  end

endmodule

// File: tb/tb_register_status_rename_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Register status rename table testbench
// Drives directed access items (register zero, append priority, tag-matched
// write bypass, stale writes, suppressed appends, clear) and then random
// rename/commit traffic, mostly in issue order with noise items mixed in,
// under two sender/receiver stall mixes and then with no stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_register_status_rename_table_top import rsrt_pkg::*;;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_IN_FLIGHT = 24;

  typedef logic [RSRT_TAG_BITS-1:0]   tag_t;
  typedef logic [RSRT_DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    reg_id_t dst;
    tag_t    tag;
  } rename_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   src_idle_pct = 15;
  int   sink_idle_pct = 52;
  int   cycles = 0;

  rename_t in_flight[$];
  tag_t    next_tag = '0;

  rsrt_in_if  in_ch ();
  rsrt_out_if out_ch ();

  register_status_rename_table_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  register_status_rename_table_checker u_lookup_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[register_status_rename_table_top] ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic clr, input logic wen, input reg_id_t wreg,
                           input data_t wval, input tag_t wtag, input logic aen,
                           input reg_id_t areg, input tag_t atag,
                           input reg_id_t sa, input reg_id_t sb);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.clear       <= clr;
    in_ch.write_en    <= wen;
    in_ch.write_reg   <= wreg;
    in_ch.write_value <= wval;
    in_ch.write_tag   <= wtag;
    in_ch.append_en   <= aen;
    in_ch.append_reg  <= areg;
    in_ch.append_tag  <= atag;
    in_ch.src_a       <= sa;
    in_ch.src_b       <= sb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic reg_id_t pick_src(input reg_id_t wreg, input reg_id_t areg);
    case ($urandom_range(3))
      0: return wreg;
      1: return areg;
      2: return reg_id_t'($urandom_range(7));
      default: return reg_id_t'($urandom_range(31));
    endcase
  endfunction

  // mostly rename/commit in issue order, with stale commits, clears and noise
  task automatic send_random_item();
    logic    clr, wen, aen;
    reg_id_t wreg, areg, sa, sb;
    data_t   wval;
    tag_t    wtag, atag;
    int      idx;
    if ($urandom_range(99) < 10) begin
      clr  = 1'($urandom);
      wen  = 1'($urandom);
      wreg = reg_id_t'($urandom);
      wval = $urandom;
      wtag = tag_t'($urandom);
      aen  = 1'($urandom);
      areg = reg_id_t'($urandom);
      atag = tag_t'($urandom);
      sa   = reg_id_t'($urandom);
      sb   = reg_id_t'($urandom);
      if (clr) in_flight.delete();
    end else begin
      clr  = ($urandom_range(99) < 3);
      aen  = ($urandom_range(99) < 70) && (in_flight.size() < MAX_IN_FLIGHT);
      areg = ($urandom_range(99) < 60) ? reg_id_t'($urandom_range(7))
                                       : reg_id_t'($urandom_range(31));
      atag = next_tag;
      wen  = (in_flight.size() > 0) && ($urandom_range(99) < 60);
      wreg = reg_id_t'($urandom);
      wtag = tag_t'($urandom);
      wval = $urandom;
      if (wen) begin
        idx  = ($urandom_range(99) < 80) ? 0 : $urandom_range(in_flight.size() - 1);
        wreg = in_flight[idx].dst;
        wtag = in_flight[idx].tag;
        in_flight.delete(idx);
      end
      sa = pick_src(wreg, areg);
      sb = pick_src(wreg, areg);
      if (clr) begin
        in_flight.delete();
      end else if (aen) begin
        in_flight.push_back('{dst: areg, tag: atag});
        next_tag++;
      end
    end
    send_item(clr, wen, wreg, wval, wtag, aen, areg, atag, sa, sb);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.clear       = 1'b0;
    in_ch.write_en    = 1'b0;
    in_ch.write_reg   = '0;
    in_ch.write_value = '0;
    in_ch.write_tag   = '0;
    in_ch.append_en   = 1'b0;
    in_ch.append_reg  = '0;
    in_ch.append_tag  = '0;
    in_ch.src_a       = '0;
    in_ch.src_b       = '0;
    out_ch.ready      = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle table
    send_item(0, 0, 0,  32'h0000_0000, 0,  0, 0,  0,  0,  0);
    // write with matching tag bypasses
    send_item(0, 1, 1,  32'hFFFF_FFFF, 0,  0, 0,  0,  1,  2);
    send_item(0, 0, 0,  32'h0000_0000, 0,  1, 5,  31, 5,  1);
    // stale write stores value, stays busy
    send_item(0, 1, 5,  32'hAAAA_AAAA, 30, 0, 0,  0,  5,  5);
    send_item(0, 1, 5,  32'h5555_5555, 31, 0, 0,  0,  5,  0);
    // append wins over write on the same register
    send_item(0, 1, 7,  32'h1234_5678, 0,  1, 7,  3,  7,  7);
    // append suppressed by write with the same tag
    send_item(0, 1, 8,  32'hDEAD_BEEF, 9,  1, 9,  9,  8,  9);
    send_item(0, 0, 0,  32'h0000_0000, 0,  0, 0,  0,  9,  7);
    // register zero reads zero and not busy, keeps its tag
    send_item(0, 1, 0,  32'hFFFF_FFFF, 0,  1, 0,  17, 0,  0);
    send_item(0, 0, 0,  32'h0000_0000, 0,  0, 0,  0,  0,  31);
    send_item(0, 0, 0,  32'h0000_0000, 0,  1, 31, 31, 31, 0);
    // clear drops busy and ignores write and append
    send_item(1, 1, 31, 32'h0000_0000, 31, 1, 12, 4,  31, 12);
    send_item(0, 0, 0,  32'h0000_0000, 0,  0, 0,  0,  31, 12);
    send_item(0, 0, 0,  32'h0000_0000, 0,  1, 3,  10, 3,  3);
    send_item(0, 0, 0,  32'h0000_0000, 0,  1, 3,  11, 3,  0);
    send_item(0, 1, 3,  32'h0F0F_0F0F, 10, 0, 0,  0,  3,  3);
    send_item(0, 1, 3,  32'hFFFF_FFFF, 11, 1, 4,  12, 3,  4);
    send_item(1, 0, 0,  32'h0000_0000, 0,  0, 0,  0,  3,  4);
    send_item(1, 1, 31, 32'hFFFF_FFFF, 31, 1, 31, 31, 31, 31);
    send_item(0, 1, 31, 32'hFFFF_FFFF, 31, 1, 31, 31, 31, 31);
    send_item(0, 0, 0,  32'h0000_0000, 0,  0, 0,  0,  31, 31);
    hold_until_drained();

    repeat (RANDOM_ITEMS / 3) send_random_item();
    hold_until_drained();

    src_idle_pct  = 52;
    sink_idle_pct = 15;
    repeat (RANDOM_ITEMS / 3) send_random_item();
    hold_until_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) send_random_item();
    hold_until_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[register_status_rename_table_top] OK");
    end else begin
      $display("[register_status_rename_table_top] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rsrt_pkg.sv
rtl/rsrt_if.sv
rtl/rsrt_ram.sv
rtl/rsrt_table.sv
rtl/rsrt_resolve.sv
rtl/register_status_rename_table_top.sv
tb/register_status_rename_table_checker.sv
tb/tb_register_status_rename_table_top.sv
